// ===== src/local_extremum_3x3_classifier_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 local extremum classifier
// Shared concurrent assertion forms; the asserting scope must provide clk and
// rst_n.
// ----------------------------------------------------------------------------
`ifndef LOCAL_EXTREMUM_3X3_CLASSIFIER_DEFINES_SVH
`define LOCAL_EXTREMUM_3X3_CLASSIFIER_DEFINES_SVH

// same-cycle implication, off during reset
`define LEC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define LEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define LEC_ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lec_pkg.sv =====
// ----------------------------------------------------------------------------
// lec_pkg
// Word types and register codes of the 3x3 local extremum classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lec_pkg;

  localparam int PIXEL_W    = 8;   // pixel field width on the ports
  localparam int POS_W      = 6;   // row / column field width on the ports
  localparam int CFG_DATA_W = 7;   // widest configuration register
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS = 2'd1;

  localparam logic [CFG_DATA_W-1:0] RESET_SIZE = 7'd20;
  localparam logic [CFG_DATA_W-1:0] MIN_SIZE   = 7'd2;

  typedef enum logic [1:0] {
    PEAK_NONE = 2'd0,
    PEAK_MAX  = 2'd1,
    PEAK_MIN  = 2'd2
  } peak_kind_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_value;
    logic               frame_start;
  } lec_in_word_t;

  typedef struct packed {
    logic [POS_W-1:0]   cell_row;
    logic [POS_W-1:0]   cell_col;
    logic [PIXEL_W-1:0] cell_value;
    peak_kind_t         peak_kind;
    logic               last_of_item;
    logic               last_of_frame;
  } lec_out_word_t;

endpackage

// ===== src/lec_if.sv =====
// ----------------------------------------------------------------------------
// lec_in_if / lec_out_if
// Valid/ready channels carrying pixel words in and classified-cell words out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lec_in_if
  import lec_pkg::*;
;
  logic         valid;
  logic         ready;
  lec_in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lec_out_if
  import lec_pkg::*;
;
  logic          valid;
  logic          ready;
  lec_out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/local_extremum_3x3_classifier.sv =====
// Path: a pixel word accepted on in_ch passes the stage register, then the
//   result register, before its first result word is offered on out_ch.
// Throughput: one pixel per cycle while out_ch is not stalled and each pixel
//   yields at most one result; more results hold the stage register longer.
// Reset (rst_n low, synchronous): sizes to 20x20, position, window and both
//   pipeline valids cleared; the line stores are not cleared.
// ----------------------------------------------------------------------------
// local_extremum_3x3_classifier
// Raster-order 3x3 strict local max / min detector with two line stores.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module local_extremum_3x3_classifier
  import lec_pkg::*;
#(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lec_in_if.sink                in_ch,
  lec_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PB = (PIXEL_BITS < PIXEL_W) ? PIXEL_BITS : PIXEL_W;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam logic [CFG_DATA_W-1:0] MAX_R = CFG_DATA_W'(MAX_ROWS);
  localparam logic [CFG_DATA_W-1:0] MAX_C = CFG_DATA_W'(MAX_COLS);

  typedef logic [PB-1:0] pix_t;

  // strict 8-neighbour test of grid cell (ci, cj); rok/cok flag grid rows and
  // columns that lie inside the frame, bit 3 stands for beyond the grid
  function automatic peak_kind_t classify(input pix_t g [3][3],
                                          input logic [1:0] ci,
                                          input logic [1:0] cj,
                                          input logic [3:0] rok,
                                          input logic [3:0] cok);
    pix_t       v;
    pix_t       n;
    logic       above;
    logic       below;
    logic [1:0] i;
    logic [1:0] j;
    peak_kind_t k;
    v     = g[ci][cj];
    above = 1'b1;
    below = 1'b1;
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        i = 2'(int'(ci) + dr - 1);
        j = 2'(int'(cj) + dc - 1);
        if (!(dr == 1 && dc == 1) && rok[i] && cok[j]) begin
          n = g[i][j];
          if (n >= v) above = 1'b0;
          if (n <= v) below = 1'b0;
        end
      end
    end
    if (above)      k = PEAK_MAX;
    else if (below) k = PEAK_MIN;
    else            k = PEAK_NONE;
    return k;
  endfunction

  // configuration registers
  logic [CFG_DATA_W-1:0] rows_r, cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= RESET_SIZE;
      cols_r <= RESET_SIZE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_ROWS: rows_r <= cfg_wdata;
        CFG_FRAME_COLS: cols_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [CFG_DATA_W-1:0] nr, nc;
  always_comb begin
    nr = (rows_r < MIN_SIZE) ? MIN_SIZE : ((rows_r > MAX_R) ? MAX_R : rows_r);
    nc = (cols_r < MIN_SIZE) ? MIN_SIZE : ((cols_r > MAX_C) ? MAX_C : cols_r);
  end

  // pipeline control and state
  logic          s1_valid_r;
  logic [3:0]    s1_pend_r;
  pix_t          s1_pix_r;
  logic [RW-1:0] s1_pr_r;
  logic [CW-1:0] s1_pc_r;
  logic          s1_fwd_r;
  pix_t          s1_ftop_r, s1_fmid_r;
  pix_t          rd_old_r, rd_new_r;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  pix_t          wc_a_r [3];
  pix_t          wc_b_r [3];
  logic          out_valid_r;
  lec_out_word_t out_data_r;

  pix_t old_mem [MAX_COLS];
  pix_t new_mem [MAX_COLS];

  logic in_acc, out_load, s1_retire;
  logic pend_single;

  // placement of the incoming pixel
  logic [CW-1:0] c0, pc_new;
  logic [RW-1:0] r0, pr_new;
  logic [RW:0]   r1, rn;
  logic [CW:0]   cn;
  logic [3:0]    exist_new;
  logic          wrap_c;

  always_comb begin
    c0     = in_ch.data.frame_start ? '0 : col_r;
    r0     = in_ch.data.frame_start ? '0 : row_r;
    wrap_c = CFG_DATA_W'(c0) >= nc;
    r1     = wrap_c ? ({1'b0, r0} + 1'b1) : {1'b0, r0};
    pc_new = wrap_c ? '0 : c0;
    pr_new = (CFG_DATA_W'(r1) >= nr) ? '0 : r1[RW-1:0];

    cn = {1'b0, pc_new} + 1'b1;
    rn = {1'b0, pr_new} + 1'b1;
    if (CFG_DATA_W'(cn) >= nc) begin
      col_nxt = '0;
      row_nxt = (CFG_DATA_W'(rn) >= nr) ? '0 : rn[RW-1:0];
    end else begin
      col_nxt = cn[CW-1:0];
      row_nxt = pr_new;
    end

    // cells completed by this pixel, in raster order
    exist_new[0] = (pr_new != '0) && (pc_new != '0);
    exist_new[1] = (pr_new != '0) && (CFG_DATA_W'(pc_new) == nc - 1'b1);
    exist_new[2] = exist_new[0] && (CFG_DATA_W'(pr_new) == nr - 1'b1);
    exist_new[3] = exist_new[1] && (CFG_DATA_W'(pr_new) == nr - 1'b1);
  end

  // handshake
  always_comb begin
    pend_single = (s1_pend_r & (s1_pend_r - 4'd1)) == 4'd0;
    out_load    = s1_valid_r && (s1_pend_r != 4'd0) && (!out_valid_r || out_ch.ready);
    s1_retire   = s1_valid_r && ((s1_pend_r == 4'd0) || (out_load && pend_single));
    in_ch.ready = !s1_valid_r || s1_retire;
    in_acc      = in_ch.valid && in_ch.ready;
  end

  // window grid of the stage item
  pix_t       grid [3][3];
  pix_t       col2_top, col2_mid;
  logic [3:0] rok, cok;
  logic [1:0] sel;
  logic [1:0] ci, cj;
  lec_out_word_t res;

  always_comb begin
    col2_top = s1_fwd_r ? s1_ftop_r : rd_old_r;
    col2_mid = s1_fwd_r ? s1_fmid_r : rd_new_r;
    for (int i = 0; i < 3; i++) begin
      grid[i][0] = wc_b_r[i];
      grid[i][1] = wc_a_r[i];
    end
    grid[0][2] = col2_top;
    grid[1][2] = col2_mid;
    grid[2][2] = s1_pix_r;

    rok = {1'b0, 1'b1, s1_pr_r != '0, s1_pr_r > RW'(1)};
    cok = {1'b0, 1'b1, s1_pc_r != '0, s1_pc_r > CW'(1)};

    // lowest pending cell goes next
    if (s1_pend_r[0])      sel = 2'd0;
    else if (s1_pend_r[1]) sel = 2'd1;
    else if (s1_pend_r[2]) sel = 2'd2;
    else                   sel = 2'd3;

    ci = sel[1] ? 2'd2 : 2'd1;
    cj = sel[0] ? 2'd2 : 2'd1;

    res.cell_row      = sel[1] ? POS_W'(s1_pr_r) : POS_W'(s1_pr_r - 1'b1);
    res.cell_col      = sel[0] ? POS_W'(s1_pc_r) : POS_W'(s1_pc_r - 1'b1);
    res.cell_value    = PIXEL_W'(grid[ci][cj]);
    res.peak_kind     = classify(grid, ci, cj, rok, cok);
    res.last_of_item  = pend_single;
    res.last_of_frame = (sel == 2'd3);
  end

  // position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (in_acc) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // stage register; forward the retiring item's store write on an address hit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_pend_r  <= '0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
      s1_pend_r  <= exist_new;
    end else begin
      if (s1_retire) s1_valid_r <= 1'b0;
      if (out_load)  s1_pend_r  <= s1_pend_r & (s1_pend_r - 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r  <= in_ch.data.pixel_value[PB-1:0];
      s1_pr_r   <= pr_new;
      s1_pc_r   <= pc_new;
      s1_fwd_r  <= s1_retire && (s1_pc_r == pc_new);
      s1_ftop_r <= col2_mid;
      s1_fmid_r <= s1_pix_r;
    end
  end

  // line stores: write on retire, registered read on accept
  always_ff @(posedge clk) begin
    if (s1_retire) old_mem[s1_pc_r] <= col2_mid;
    if (in_acc)    rd_old_r <= old_mem[pc_new];
  end

  always_ff @(posedge clk) begin
    if (s1_retire) new_mem[s1_pc_r] <= s1_pix_r;
    if (in_acc)    rd_new_r <= new_mem[pc_new];
  end

  // window shift on retire
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        wc_a_r[i] <= '0;
        wc_b_r[i] <= '0;
      end
    end else if (s1_retire) begin
      for (int i = 0; i < 3; i++) begin
        wc_b_r[i] <= wc_a_r[i];
        wc_a_r[i] <= grid[i][2];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data_r <= res;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

// ===== src/lec_checker.sv =====
// ----------------------------------------------------------------------------
// lec_checker
// Port-level checks on the classifier's result channel, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "local_extremum_3x3_classifier_defines.svh"

module lec_checker
  import lec_pkg::*;
(
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input lec_out_word_t out_data
);

  // a stalled word holds
  `LEC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result word changed while stalled")

  // bottom-right cell is always the last word of its pixel
  `LEC_ASSERT_IMPL(a_frame_end_last, out_valid && out_data.last_of_frame, out_data.last_of_item, "frame end without item end")

  // frames are at least 2x2, so the final cell is never on row or column zero
  `LEC_ASSERT_IMPL(a_frame_end_pos, out_valid && out_data.last_of_frame, (out_data.cell_row != '0) && (out_data.cell_col != '0), "frame end at row or column zero")

  // reset empties the result register
  `LEC_ASSERT_ALWAYS_NEXT(a_reset_empty, !rst_n, !out_valid, "result valid after reset")

endmodule

bind local_extremum_3x3_classifier lec_checker u_lec_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
